FILE: hw/rtl/planar_tile_bitplane_encoder_macros.svh
// ----------------------------------------------------------------------------
// Planar tile bitplane encoder - assertion macros
// Shorthand for the concurrent checks on the encoder's ports.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TILE_BITPLANE_ENCODER_MACROS_SVH
`define PLANAR_TILE_BITPLANE_ENCODER_MACROS_SVH

// Next-cycle implication, muted while reset is held.
`define PTBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also looks across reset.
`define PTBE_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ptbe_pkg.sv
// ----------------------------------------------------------------------------
// ptbe_pkg
// Shared types and constants of the planar tile bitplane encoder.
// ----------------------------------------------------------------------------
package ptbe_pkg;

    localparam int TILE_SIDE   = 8;
    localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
    localparam int PLANES      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int POS_W  = $clog2(TILE_PIXELS);
    localparam int AXIS_W = $clog2(TILE_SIDE);

    // register indexes on the config port
    localparam logic CFG_PALETTE_SIZE = 1'b0;
    localparam logic CFG_TILE_FORMAT  = 1'b1;

    localparam logic [8:0] PALETTE_RESET = 9'd16;

    // last word number of a burst: 1, 2 or 4 plane pairs of 8 rows
    localparam logic [4:0] BURST_END_2P = 5'd7;
    localparam logic [4:0] BURST_END_4P = 5'd15;
    localparam logic [4:0] BURST_END_8P = 5'd31;

    // one classified pixel, front to back
    typedef struct packed {
        logic [7:0]       idx;
        logic [POS_W-1:0] pos;
        logic             linear;
        logic             last;
        logic             fold;       // index above size-1, needs the modulo
        logic [8:0]       modulus;    // max(size,2) - 1
        logic [4:0]       burst_end;
    } t_item;

    // all plane bytes of one tile row; bit 7 of a byte is column 0
    typedef logic [PLANES-1:0][TILE_SIDE-1:0] t_row;

endpackage

FILE: hw/rtl/ptbe_front.sv
// ----------------------------------------------------------------------------
// ptbe_front
// Input handshake, config registers, tile position and item classification.
// ----------------------------------------------------------------------------
module ptbe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [8:0]         i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_pixel_index,
    input  logic               i_queue_full,
    output logic               o_push,
    output ptbe_pkg::t_item    o_item
);
    import ptbe_pkg::*;

    logic [8:0]       r_palette_size;
    logic             r_tile_format;
    logic [POS_W-1:0] r_pos;
    logic [8:0]       size_eff;
    logic [8:0]       modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= PALETTE_RESET;
            r_tile_format  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PALETTE_SIZE: r_palette_size <= i_cfg_wdata;
                CFG_TILE_FORMAT:  r_tile_format  <= i_cfg_wdata[0];
                default:          r_tile_format  <= r_tile_format;
            endcase
        end
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= r_pos + POS_W'(1);
        end
    end

    // sizes 0 and 1 behave as 2
    assign size_eff = (r_palette_size < 9'd2) ? 9'd2 : r_palette_size;
    assign modulus  = size_eff - 9'd1;

    always_comb begin
        o_item.idx     = i_pixel_index;
        o_item.pos     = r_pos;
        o_item.linear  = r_tile_format;
        o_item.last    = (r_pos == POS_W'(TILE_PIXELS - 1));
        o_item.fold    = !r_tile_format && ({1'b0, i_pixel_index} > modulus);
        o_item.modulus = modulus;
        if (r_palette_size > 9'd16) begin
            o_item.burst_end = BURST_END_8P;
        end else if (r_palette_size > 9'd4) begin
            o_item.burst_end = BURST_END_4P;
        end else begin
            o_item.burst_end = BURST_END_2P;
        end
    end

endmodule

FILE: hw/rtl/ptbe_queue.sv
// ----------------------------------------------------------------------------
// ptbe_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module ptbe_queue #(
    parameter int DEPTH = ptbe_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ptbe_pkg::t_item    i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_head_valid,
    output ptbe_pkg::t_item    o_head
);
    import ptbe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/ptbe_back.sv
// ----------------------------------------------------------------------------
// ptbe_back
// Index fold (bit-serial modulo), plane row storage, burst and output stage.
// ----------------------------------------------------------------------------
module ptbe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  ptbe_pkg::t_item    i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_tile_word,
    output logic               o_last_of_tile
);
    import ptbe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_BURST = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_item            r_cur, n_cur;
    logic [8:0]       r_rem, n_rem;
    logic [7:0]       r_dvd, n_dvd;
    logic [2:0]       r_cnt, n_cnt;
    logic [4:0]       r_burst, n_burst;
    logic [4:0]       r_end, n_end;
    t_row             r_rows [TILE_SIDE];

    logic             r_ovalid;
    logic [15:0]      r_oword;
    logic             r_olast;

    logic             out_free;
    logic             emit;
    logic [15:0]      emit_word;
    logic             emit_last;
    logic             wr_en;
    logic [7:0]       wr_idx;
    logic [POS_W-1:0] wr_pos;
    logic [8:0]       d_shift;
    logic [8:0]       d_rem;
    t_row             rd_row;
    logic [1:0]       pair;

    assign out_free = !r_ovalid || i_ready;

    // one quotient bit per cycle
    assign d_shift = {r_rem[7:0], r_dvd[7]};
    assign d_rem   = (d_shift >= r_cur.modulus) ? d_shift - r_cur.modulus : d_shift;

    assign rd_row = r_rows[r_burst[AXIS_W-1:0]];
    assign pair   = r_burst[4:3];

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_cnt     = r_cnt;
        n_burst   = r_burst;
        n_end     = r_end;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_word = {8'h00, i_head.idx};
        emit_last = i_head.last;
        wr_en     = 1'b0;
        wr_idx    = i_head.idx;
        wr_pos    = i_head.pos;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.linear) begin
                        if (out_free) begin
                            emit  = 1'b1;
                            o_pop = 1'b1;
                        end
                    end else if (i_head.fold) begin
                        o_pop   = 1'b1;
                        n_cur   = i_head;
                        n_rem   = '0;
                        n_dvd   = i_head.idx;
                        n_cnt   = 3'd7;
                        n_state = ST_DIV;
                    end else begin
                        o_pop = 1'b1;
                        wr_en = 1'b1;
                        if (i_head.last) begin
                            n_burst = '0;
                            n_end   = i_head.burst_end;
                            n_state = ST_BURST;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem = d_rem;
                n_dvd = {r_dvd[6:0], 1'b0};
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    wr_en  = 1'b1;
                    wr_idx = d_rem[7:0] + 8'd1;
                    wr_pos = r_cur.pos;
                    if (r_cur.last) begin
                        n_burst = '0;
                        n_end   = r_cur.burst_end;
                        n_state = ST_BURST;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BURST: begin
                emit_word = {rd_row[{pair, 1'b1}], rd_row[{pair, 1'b0}]};
                emit_last = (r_burst == r_end);
                if (out_free) begin
                    emit    = 1'b1;
                    n_burst = r_burst + 5'd1;
                    if (r_burst == r_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cur   <= n_cur;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_cnt   <= n_cnt;
        r_burst <= n_burst;
        r_end   <= n_end;
    end

    // plane rows: column 0 restarts the row, later columns OR their bit in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < TILE_SIDE; r++) begin
                r_rows[r] <= '0;
            end
        end else if (wr_en) begin
            for (int r = 0; r < TILE_SIDE; r++) begin
                for (int p = 0; p < PLANES; p++) begin
                    for (int c = 0; c < TILE_SIDE; c++) begin
                        if (wr_pos[POS_W-1:AXIS_W] == AXIS_W'(r)) begin
                            if (wr_pos[AXIS_W-1:0] == '0) begin
                                r_rows[r][p][TILE_SIDE-1-c] <= (c == 0) ? wr_idx[p] : 1'b0;
                            end else if (wr_pos[AXIS_W-1:0] == AXIS_W'(c)) begin
                                r_rows[r][p][TILE_SIDE-1-c] <=
                                    r_rows[r][p][TILE_SIDE-1-c] | wr_idx[p];
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (emit) begin
            r_oword <= emit_word;
            r_olast <= emit_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_tile_word    = r_oword;
    assign o_last_of_tile = r_olast;

endmodule

FILE: hw/rtl/planar_tile_bitplane_encoder.sv
// ----------------------------------------------------------------------------
// planar_tile_bitplane_encoder
// Turns the 64 palette indices of an 8x8 tile into bitplane words or bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one pixel index per item, raster
//   order within the tile. Output channel (o_valid / i_ready) gives 16-bit
//   tile words with a last-of-tile flag.
//   Planar mode: indices at or above the palette size fold to
//   1 + index mod (size - 1); after the 64th pixel a burst of 8, 16 or 32
//   words follows (planes 0/1, 2/3, 4/5, 6/7; even plane in the low byte).
//   Linear mode: every item gives one word, the index in the low byte.
//   A linear item passes through the item queue and then the output register.
//   A planar pixel goes from the queue head into the plane rows, after the fold
//   when it folds (the modulo unit resolves one quotient bit per cycle). The
//   burst then runs one word per cycle while the receiver keeps i_ready high.
//   A 2-entry item queue sits between the classifying front end and the back
//   end, so input keeps flowing while a result waits in the output register.
//   When the receiver stalls, the output register holds and the queue fills;
//   o_ready drops once it is full.
//   Reset (synchronous) clears the plane rows, the tile position, the queue
//   and the output register; palette size returns to 16, format to planar.
//   Config registers must be written only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module planar_tile_bitplane_encoder #(
    parameter int QUEUE_DEPTH = ptbe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_tile_word,
    output logic        o_last_of_tile
);
    import ptbe_pkg::*;

    logic  push;
    t_item front_item;
    logic  queue_full;
    logic  pop;
    logic  head_valid;
    t_item head_item;

    // front: config, position count, classification
    ptbe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_index (i_pixel_index),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    ptbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (front_item),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_item)
    );

    // back: fold, plane rows, burst, output register
    ptbe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tile_word    (o_tile_word),
        .o_last_of_tile (o_last_of_tile)
    );

endmodule

FILE: hw/rtl/ptbe_checker.sv
// ----------------------------------------------------------------------------
// ptbe_checker
// Port-level checks on the planar tile bitplane encoder.
// ----------------------------------------------------------------------------
`include "planar_tile_bitplane_encoder_macros.svh"

module ptbe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_pixel_index,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [15:0] o_tile_word,
    input  logic        o_last_of_tile
);

    logic        in_stall;
    logic        out_stall;
    logic        last_taken;
    logic        last_shown;
    logic [16:0] out_data;

    assign in_stall   = i_valid && !o_ready;
    assign out_stall  = o_valid && !i_ready;
    assign last_taken = o_valid && i_ready && o_last_of_tile;
    assign last_shown = o_valid && o_last_of_tile;
    assign out_data   = {o_tile_word, o_last_of_tile};

    `PTBE_ASSERT_NEXT(a_in_hold, in_stall, i_valid && $stable(i_pixel_index), "input item changed")
    `PTBE_ASSERT_NEXT(a_out_hold, out_stall, o_valid, "output item dropped while stalled")
    `PTBE_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_data), "output changed while stalled")
    `PTBE_ASSERT_NEXT_ANY(a_reset_clean, !i_rst_n, !o_valid && o_ready, "not empty after reset")
    `PTBE_ASSERT_NEXT(a_one_last, last_taken, !last_shown, "two tile ends back to back")

endmodule

bind planar_tile_bitplane_encoder ptbe_checker u_ptbe_checker (.*);

FILE: sim/planar_tile_bitplane_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_bitplane_encoder_tb
// Self-checking bench for the 8x8 tile bitplane encoder. Pixel indices go in
// over a valid/ready channel. An in-bench copy of the tile encoder predicts
// every output word, and each word is checked as it leaves. Palette size and
// tile format are changed between phases, including in the middle of a tile.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module planar_tile_bitplane_encoder_tb;
    import ptbe_pkg::*;

    localparam int  RANDOM_ITEMS = 280;
    localparam int  QUIET_CYCLES = 32;      // covers two folding items in the queue
    localparam int  CYCLE_LIMIT  = 200000;
    localparam logic FMT_PLANAR  = 1'b0;
    localparam logic FMT_LINEAR  = 1'b1;

    typedef struct {
        logic [15:0] word;
        logic        last;
    } t_tile_word;

    // DUT ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [8:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_pixel_index;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_tile_word;
    logic        o_last_of_tile;

    // encoder copy: plane rows, tile position and registers
    logic [7:0]  plane_rows [0:63];
    logic [5:0]  tile_pos;
    logic [8:0]  palette_size;
    logic        tile_format;

    t_tile_word  pending_words [$];
    int          errors;
    int          cycles;
    bit          sender_burst;             // no gaps between items
    bit          receiver_burst;           // no stalls on results

    planar_tile_bitplane_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel_index  (i_pixel_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tile_word    (o_tile_word),
        .o_last_of_tile (o_last_of_tile)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Encoder copy. Called once per accepted pixel item.
    // ------------------------------------------------------------------------
    task automatic encode_pixel(input logic [7:0] pix);
        logic [5:0] pos;
        logic [2:0] col;
        logic [2:0] row;
        int         size;
        int         modulus;
        int         value;
        int         pairs;
        int         slot;
        t_tile_word w;
        pos      = tile_pos;
        col      = pos[2:0];
        row      = pos[5:3];
        tile_pos = pos + 6'd1;

        // linear: the index goes straight out, planes untouched
        if (tile_format == FMT_LINEAR) begin
            w.word = {8'h00, pix};
            w.last = (pos == 6'd63);
            pending_words.push_back(w);
            return;
        end

        // fold into the palette; sizes 0 and 1 behave as 2
        size    = (palette_size < 2) ? 2 : int'(palette_size);
        modulus = size - 1;
        value   = pix;
        if (value > modulus)
            value = 1 + value % modulus;

        // spread bits over the row bytes; column 0 starts the row afresh,
        // later columns OR their bit over whatever the row already holds
        for (int p = 0; p < PLANES; p++) begin
            slot = p * TILE_SIDE + row;
            if (col == 3'd0)
                plane_rows[slot] = 8'h00;
            plane_rows[slot][7 - col] = plane_rows[slot][7 - col] | value[p];
        end

        if (pos == 6'd63) begin
            pairs = 1;
            if (palette_size > 4)
                pairs = 2;
            if (palette_size > 16)
                pairs = 4;
            for (int p = 0; p < pairs; p++) begin
                for (int y = 0; y < TILE_SIDE; y++) begin
                    w.word = {plane_rows[(2 * p + 1) * TILE_SIDE + y],
                              plane_rows[(2 * p) * TILE_SIDE + y]};
                    w.last = (p == pairs - 1) && (y == TILE_SIDE - 1);
                    pending_words.push_back(w);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver side. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] pix);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_index <= pix;
        do @(posedge i_clk); while (!o_ready);
        encode_pixel(pix);
        @(negedge i_clk);
    endtask

    // drop valid, let every expected word out, then let the back end settle
    task automatic wait_idle;
        i_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [8:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == CFG_PALETTE_SIZE)
            palette_size = data;
        else
            tile_format = data[0];
        @(negedge i_clk);
    endtask

    function automatic logic [8:0] pick_palette();
        logic [8:0] corners [12];
        corners = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5,
                    9'd16, 9'd17, 9'd255, 9'd256, 9'd257, 9'd511};
        if ($urandom_range(0, 1) == 0)
            return corners[$urandom_range(0, 11)];
        return 9'($urandom_range(0, 511));
    endfunction

    // half in-palette indices, half anything (exercises the fold)
    function automatic logic [7:0] pick_pixel(input logic [8:0] size);
        int top;
        top = (size > 256) ? 255 : int'(size) - 1;
        if (size >= 2 && $urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, top));
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset config (16 colors, planar): fold boundaries and bit patterns, row 0
    task automatic test_planar_fold;
        logic [7:0] pix [8];
        pix = '{8'd0, 8'd255, 8'd15, 8'd16, 8'd17, 8'hAA, 8'h55, 8'd1};
        foreach (pix[i])
            send_pixel(pix[i]);
    endtask

    // switch to linear mid-tile: index extremes pass unchanged
    task automatic test_linear_extremes;
        logic [7:0] pix [5];
        pix = '{8'd0, 8'd255, 8'h80, 8'h7F, 8'h01};
        wait_idle();
        write_reg(CFG_TILE_FORMAT, {8'd0, FMT_LINEAR});
        foreach (pix[i])
            send_pixel(pix[i]);
    endtask

    // sizes below two (modulus 1) and above 256 (no fold, eight planes)
    task automatic test_palette_edges;
        wait_idle();
        write_reg(CFG_TILE_FORMAT, {8'd0, FMT_PLANAR});
        write_reg(CFG_PALETTE_SIZE, 9'd0);
        send_pixel(8'd255);
        send_pixel(8'd2);
        send_pixel(8'd1);
        wait_idle();
        write_reg(CFG_PALETTE_SIZE, 9'd257);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd3);
        wait_idle();
        write_reg(CFG_PALETTE_SIZE, 9'd511);
        send_pixel(8'd255);
        send_pixel(8'd0);
    endtask

    // Phases with a fresh config each. Planar phases finish the current tile
    // so that bursts come out; linear phases are short runs that may land in
    // the middle of a tile and leave stale plane rows behind.
    task automatic test_random_tiles;
        int         sent;
        int         count;
        logic [8:0] size;
        logic       fmt;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            size = pick_palette();
            fmt  = ($urandom_range(0, 3) == 0) ? FMT_LINEAR : FMT_PLANAR;
            write_reg(CFG_PALETTE_SIZE, size);
            write_reg(CFG_TILE_FORMAT, {8'd0, fmt});
            sender_burst = ($urandom_range(0, 3) == 0);
            if (fmt == FMT_LINEAR)
                count = $urandom_range(1, 24);
            else
                count = 64 - int'(tile_pos);
            repeat (count)
                send_pixel(pick_pixel(size));
            sent += count;
        end
        sender_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall before each word, with stall-free stretches.
    // Ready changes once per falling edge at most.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        forever begin
            if ($urandom_range(0, 31) == 0)
                receiver_burst = ~receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each accepted word against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tile_word w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: tile_word %h last_of_tile %b",
                       o_tile_word, o_last_of_tile);
                errors++;
            end else begin
                w = pending_words.pop_front();
                if (o_tile_word !== w.word) begin
                    $error("tile_word mismatch: expected %h, actual %h",
                           w.word, o_tile_word);
                    errors++;
                end
                if (o_last_of_tile !== w.last) begin
                    $error("last_of_tile mismatch: expected %b, actual %b",
                           w.last, o_last_of_tile);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_PALETTE_SIZE;
        i_cfg_wdata    = 9'd0;
        i_valid        = 1'b0;
        i_pixel_index  = 8'd0;
        i_ready        = 1'b0;
        errors         = 0;
        cycles         = 0;
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;

        // reset state of the encoder copy
        foreach (plane_rows[i])
            plane_rows[i] = 8'h00;
        tile_pos     = 6'd0;
        palette_size = PALETTE_RESET;
        tile_format  = FMT_PLANAR;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_planar_fold();
        test_linear_extremes();
        test_palette_edges();
        test_random_tiles();

        // every item is in; let the last words drain
        wait_idle();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
